// ===== sv/aokv_pkg.sv =====
// Shared sizes for the append-only key/value table.
// Used by append_only_key_value_table_top; no dependencies.
`timescale 1ns / 1ps

package aokv_pkg;

  // Table geometry
  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  // Port widths of the key, value and read_value fields
  localparam int PORT_WIDTH  = 32;

  // Stored widths: only the low bits of a port word are kept
  localparam int KEY_BITS    = (KEY_WIDTH < PORT_WIDTH) ? KEY_WIDTH : PORT_WIDTH;
  localparam int VALUE_BITS  = (VALUE_WIDTH < PORT_WIDTH) ? VALUE_WIDTH : PORT_WIDTH;
  localparam int ENTRY_BITS  = KEY_BITS + VALUE_BITS;

  // Entry index and fill count widths
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W       = $clog2(ENTRIES + 1);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;

  // Action codes
  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_GET = 1'b1;

endpackage

// ===== sv/aokv_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; instanced by append_only_key_value_table_top.
`timescale 1ns / 1ps

module aokv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word and read one word; the read data is registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/append_only_key_value_table_top.sv =====
// Top level of the append-only key/value table.
// Depends on aokv_pkg and aokv_ram.
`timescale 1ns / 1ps

// A table of up to ENTRIES key/value pairs, filled in order, held in one
// synchronous RAM (key and value side by side in each word) with a fill
// count in a register. Each input word is either a set (update the value
// of an existing key, else append the pair) or a get (return the stored
// value with a hit flag); exactly one result word follows each input word.
// The search reads one stored entry per cycle from the single RAM read
// port and stops at the first equal key or at the last filled entry; an
// empty table skips the search. One item is worked on at a time; the
// next word is taken while the previous result still waits in the output
// register. A set with a new key on a full table stores nothing and
// returns full_error. No clearing pass is needed after reset: only
// entries below the fill count are ever compared.
module append_only_key_value_table_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             action,
  input  logic [aokv_pkg::PORT_WIDTH-1:0]  key,
  input  logic [aokv_pkg::PORT_WIDTH-1:0]  value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic [aokv_pkg::PORT_WIDTH-1:0]  read_value,
  output logic                             full_error
);

  import aokv_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  cnt_t       fill_count;
  idx_t       scan_idx;
  idx_t       hit_idx;
  logic       found;
  val_t       found_val;
  logic       cur_action;
  key_t       cur_key;
  val_t       cur_value;

  logic       in_take;
  logic       out_free;
  logic       table_full;
  logic       entry_match;
  logic       scan_last;
  logic       finish_go;
  logic       do_append;
  logic       ram_wr_en;
  idx_t       ram_wr_addr;
  idx_t       ram_rd_addr;
  entry_t     ram_rd_data;

  assign in_stall    = (state != S_IDLE);
  assign in_take     = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign table_full  = (fill_count == CNT_W'(ENTRIES));
  assign entry_match = (ram_rd_data[ENTRY_BITS-1:VALUE_BITS] == cur_key);
  assign scan_last   = ((CNT_W'(scan_idx) + CNT_W'(1)) == fill_count);
  assign finish_go   = (state == S_FINISH) && out_free;
  assign do_append   = (cur_action == ACT_SET) && !found && !table_full;

  // Present entry 0 on accept, then the entry after the one being compared
  assign ram_rd_addr = (state == S_SCAN) ? scan_idx + IDX_W'(1) : '0;

  // Write back on a set: in place on a hit, at the fill count on an append
  assign ram_wr_en   = finish_go && (cur_action == ACT_SET) && (found || !table_full);
  assign ram_wr_addr = found ? hit_idx : fill_count[IDX_W-1:0];

  aokv_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (ENTRIES)
  ) u_table_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data ({cur_key, cur_value}),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequence accept, scan and finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= (fill_count == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (entry_match || scan_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
            if (do_append) begin
              fill_count <= fill_count + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latch the word and track the search
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_action <= action;
      cur_key    <= key[KEY_BITS-1:0];
      cur_value  <= value[VALUE_BITS-1:0];
      scan_idx   <= '0;
      found      <= 1'b0;
    end else if (state == S_SCAN) begin
      if (entry_match) begin
        found     <= 1'b1;
        hit_idx   <= scan_idx;
        found_val <= ram_rd_data[VALUE_BITS-1:0];
      end else begin
        scan_idx  <= scan_idx + IDX_W'(1);
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      hit        <= found;
      read_value <= ((cur_action == ACT_GET) && found) ? PORT_WIDTH'(found_val) : '0;
      full_error <= (cur_action == ACT_SET) && !found && table_full;
    end
  end

endmodule
